// ===== rtl/infix_to_prefix_converter_assert.svh =====
// assertion macros used by the converter top level
`ifndef INFIX_TO_PREFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_PREFIX_CONVERTER_ASSERT_SVH

// same-cycle property, checked outside reset
`define I2P_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define I2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/i2p_pkg.sv =====
// shared types, constants and helper functions of the infix to prefix converter
package i2p_pkg;

  localparam int MAX_CHARS = 64;
  localparam int AW        = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CW        = $clog2(MAX_CHARS + 1);

  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_OP,
    CLS_CLOSE,
    CLS_OPEN,
    CLS_OPND
  } char_cls_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // take the input request character
    logic scan_init;   // start a conversion pass
    logic scan_rd;     // read the buffered character below the scan index
    logic scan_dec;    // step the scan index down
    logic stk_rd;      // read top of the operator stack
    logic push_c;      // push the current character
    logic pop_emit;    // pop the top and append it to the result
    logic pop_drop;    // pop the top and discard it
    logic emit_c;      // append the current character to the result
    logic out_init;    // point at the newest result entry
    logic out_rd;      // read the result entry under the output index
    logic out_dec;     // step the output index down
    logic out_empty;   // present the empty result
    logic finish;      // clear the expression for the next one
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      scan_done;
    logic      sp_zero;
    logic      rc_zero;
    logic      out_last;
    logic      pop_higher;
    logic      top_is_close;
    char_cls_e cls;
  } status_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_POW) begin
      p = 2'd3;
    end else if (c == CH_MUL || c == CH_DIV) begin
      p = 2'd2;
    end else if (c == CH_ADD || c == CH_SUB) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic char_cls_e classify(input logic [7:0] c);
    char_cls_e k;
    k = CLS_OPND;
    if (c == CH_SPACE || c == CH_TAB) begin
      k = CLS_BLANK;
    end else if (prec_of(c) != 2'd0) begin
      k = CLS_OP;
    end else if (c == CH_CLOSE) begin
      k = CLS_CLOSE;
    end else if (c == CH_OPEN) begin
      k = CLS_OPEN;
    end
    return k;
  endfunction

endpackage

// ===== rtl/i2p_datapath.sv =====
// buffers, operator stack, result store and counters of the converter
module i2p_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      in_char_i,
  input  i2p_pkg::cmd_t   cmd_i,
  output i2p_pkg::status_t status_o,
  output logic [7:0]      out_char_o,
  output logic            empty_res_o,
  output logic            overflow_o,
  output logic            last_o
);
  import i2p_pkg::*;

  logic [7:0] expr_mem [MAX_CHARS];
  logic [7:0] stk_mem  [MAX_CHARS];
  logic [7:0] res_mem  [MAX_CHARS];

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] rc_q, rc_d;
  logic [AW-1:0] oidx_q, oidx_d;
  logic [7:0]    ch_q;
  logic [7:0]    top_q;
  logic [7:0]    res_q;

  logic          cnt_full;
  logic [CW-1:0] idx_m1, sp_m1, rc_m1;
  logic          emit_en;
  logic [7:0]    emit_data;
  logic          push_en;

  assign cnt_full  = (cnt_q == CW'(MAX_CHARS));
  assign idx_m1    = idx_q - CW'(1);
  assign sp_m1     = sp_q - CW'(1);
  assign rc_m1     = rc_q - CW'(1);
  assign emit_en   = (cmd_i.pop_emit || cmd_i.emit_c) && (rc_q < CW'(MAX_CHARS));
  assign emit_data = cmd_i.pop_emit ? top_q : ch_q;
  assign push_en   = cmd_i.push_c && (sp_q < CW'(MAX_CHARS));

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    idx_d  = idx_q;
    sp_d   = sp_q;
    rc_d   = rc_q;
    oidx_d = oidx_q;
    if (cmd_i.load) begin
      if (cnt_full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
    if (cmd_i.scan_init) begin
      idx_d = cnt_full ? cnt_q : cnt_q + CW'(1);
      sp_d  = '0;
      rc_d  = '0;
    end
    if (cmd_i.scan_dec) begin
      idx_d = idx_m1;
    end
    if (push_en) begin
      sp_d = sp_q + CW'(1);
    end
    if (cmd_i.pop_emit || cmd_i.pop_drop) begin
      sp_d = sp_m1;
    end
    if (emit_en) begin
      rc_d = rc_q + CW'(1);
    end
    if (cmd_i.out_init) begin
      oidx_d = rc_m1[AW-1:0];
    end
    if (cmd_i.out_dec) begin
      oidx_d = oidx_q - AW'(1);
    end
    if (cmd_i.finish) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      idx_q  <= '0;
      sp_q   <= '0;
      rc_q   <= '0;
      oidx_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      idx_q  <= idx_d;
      sp_q   <= sp_d;
      rc_q   <= rc_d;
      oidx_q <= oidx_d;
    end
  end

  // expression buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !cnt_full) begin
      expr_mem[cnt_q[AW-1:0]] <= in_char_i;
    end
    if (cmd_i.scan_rd) begin
      ch_q <= expr_mem[idx_m1[AW-1:0]];
    end
  end

  // operator stack
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stk_mem[sp_q[AW-1:0]] <= ch_q;
    end
    if (cmd_i.stk_rd) begin
      top_q <= stk_mem[sp_m1[AW-1:0]];
    end
  end

  // result store, read back newest first
  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      res_mem[rc_q[AW-1:0]] <= emit_data;
    end
    if (cmd_i.out_rd) begin
      res_q <= res_mem[oidx_q];
    end
  end

  assign status_o.scan_done    = (idx_q == '0);
  assign status_o.sp_zero      = (sp_q == '0);
  assign status_o.rc_zero      = (rc_q == '0);
  assign status_o.out_last     = (oidx_q == '0);
  assign status_o.pop_higher   = (prec_of(top_q) > prec_of(ch_q));
  assign status_o.top_is_close = (top_q == CH_CLOSE);
  assign status_o.cls          = classify(ch_q);

  assign out_char_o  = cmd_i.out_empty ? 8'h00 : res_q;
  assign empty_res_o = cmd_i.out_empty;
  assign overflow_o  = ovf_q;
  assign last_o      = cmd_i.out_empty || (oidx_q == '0);

endmodule

// ===== rtl/i2p_controller.sv =====
// sequencing state machine of the converter
module i2p_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             end_of_expr_i,
  input  i2p_pkg::status_t status_i,
  output i2p_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             result_valid_o
);
  import i2p_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SEV   = 4'd2;
  localparam logic [3:0] S_STOP  = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_FTOP  = 4'd5;
  localparam logic [3:0] S_FPOP  = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OEM   = 4'd8;
  localparam logic [3:0] S_EMPTY = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    result_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (end_of_expr_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (status_i.scan_done) begin
          state_d = S_FTOP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SEV;
        end
      end
      S_SEV: begin
        unique case (status_i.cls)
          CLS_BLANK: begin
            cmd_o.scan_dec = 1'b1;
            state_d        = S_SRD;
          end
          CLS_CLOSE: begin
            cmd_o.push_c   = 1'b1;
            cmd_o.scan_dec = 1'b1;
            state_d        = S_SRD;
          end
          CLS_OPND: begin
            cmd_o.emit_c   = 1'b1;
            cmd_o.scan_dec = 1'b1;
            state_d        = S_SRD;
          end
          default: begin
            state_d = S_STOP;
          end
        endcase
      end
      S_STOP: begin
        cmd_o.stk_rd = 1'b1;
        state_d      = S_SCMP;
      end
      S_SCMP: begin
        priority if (status_i.cls == CLS_OP) begin
          if (!status_i.sp_zero && status_i.pop_higher) begin
            cmd_o.pop_emit = 1'b1;
            state_d        = S_STOP;
          end else begin
            cmd_o.push_c   = 1'b1;
            cmd_o.scan_dec = 1'b1;
            state_d        = S_SRD;
          end
        end else begin
          // opening parenthesis: unwind to the nearest closing one
          if (!status_i.sp_zero && !status_i.top_is_close) begin
            cmd_o.pop_emit = 1'b1;
            state_d        = S_STOP;
          end else begin
            cmd_o.pop_drop = !status_i.sp_zero;
            cmd_o.scan_dec = 1'b1;
            state_d        = S_SRD;
          end
        end
      end
      S_FTOP: begin
        if (status_i.sp_zero) begin
          if (status_i.rc_zero) begin
            state_d = S_EMPTY;
          end else begin
            cmd_o.out_init = 1'b1;
            state_d        = S_ORD;
          end
        end else begin
          cmd_o.stk_rd = 1'b1;
          state_d      = S_FPOP;
        end
      end
      S_FPOP: begin
        cmd_o.pop_emit = 1'b1;
        state_d        = S_FTOP;
      end
      S_ORD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = S_OEM;
      end
      S_OEM: begin
        result_valid_o = 1'b1;
        if (status_i.out_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.out_dec = 1'b1;
          state_d       = S_ORD;
        end
      end
      S_EMPTY: begin
        result_valid_o  = 1'b1;
        cmd_o.out_empty = 1'b1;
        cmd_o.finish    = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/infix_to_prefix_converter.sv =====
// top level of the infix to prefix converter
// usage:
//   - a request is taken at a clock edge with start_i high and busy_o low; it carries
//     one character (in_char_i) and end_of_expr_i, which marks the final character
//   - plain characters load while busy_o stays low between them
//   - the end request starts the conversion: busy_o rises and the buffer is scanned
//     newest to oldest, each character read and classified; an operator or '(' also
//     reads and compares the stack top, popping entries as needed, and the leftover
//     stack entries are popped at the end
//   - results then stream out, each read from the result store and shown for one cycle
//     with result_valid_o; last_o marks the final one and busy_o drops the cycle after it
//   - the pace is set by the single read port of each of the three character memories
//   - an expression that yields nothing gives one result with empty_res_o and last_o
//   - overflow_o is high on every result of an expression that lost characters
//   - the receiver cannot stall: results must be taken as they appear
//   - reset clears the counters and the state machine; memories need no clearing
module infix_to_prefix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       busy_o,
  output logic       result_valid_o,
  output logic [7:0] out_char_o,
  output logic       empty_res_o,
  output logic       overflow_o,
  output logic       last_o
);
  import i2p_pkg::*;

  `include "infix_to_prefix_converter_assert.svh"

  cmd_t    cmd;
  status_t status;

  // sequencing: scan, stack unwind, readback
  i2p_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .end_of_expr_i  (end_of_expr_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  // character memories and counters
  i2p_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (in_char_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_char_o  (out_char_o),
    .empty_res_o (empty_res_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  // results only appear during a conversion
  `I2P_ASSERT(a_valid_busy, clk_i, rst_ni, !result_valid_o || busy_o,
              "result outside a conversion")

  // an end request always starts a conversion
  `I2P_ASSERT_NEXT(a_end_starts, clk_i, rst_ni, start_i && !busy_o && end_of_expr_i,
                   busy_o, "end request did not start conversion")

  // the final result releases the block
  `I2P_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, result_valid_o && last_o,
                   !busy_o && !result_valid_o, "block still busy after final result")

  // an empty result is a single, final one
  `I2P_ASSERT(a_empty_last, clk_i, rst_ni, !(result_valid_o && empty_res_o) || last_o,
              "empty result not marked last")

endmodule

// ===== test/infix_to_prefix_converter_tb.sv =====
// self-checking testbench for the infix to prefix converter: directed and random expressions
`timescale 1ns / 1ps

module infix_to_prefix_converter_tb;
  import i2p_pkg::*;

  // run length guard, far above the slowest correct run
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef logic [7:0] char_q_t[$];

  // one expected prefix character with its flags
  typedef struct packed {
    logic [7:0] ch;
    logic       empty;
    logic       lost;
    logic       last;
  } prefix_char_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic [7:0] in_char_i;
  logic       end_of_expr_i;
  logic       busy_o;
  logic       result_valid_o;
  logic [7:0] out_char_o;
  logic       empty_res_o;
  logic       overflow_o;
  logic       last_o;

  infix_to_prefix_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .out_char_o    (out_char_o),
    .empty_res_o   (empty_res_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  // predictor state: the characters collected so far for the current expression
  logic [7:0]   infix_mem [MAX_CHARS];
  int unsigned  infix_len;
  logic         infix_lost;

  // prefix characters still owed by the block, oldest first
  prefix_char_t expected_prefix_q[$];
  prefix_char_t prefix_head;

  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  sender_idle_pct;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // binding strength of an operator, zero for anything else
  function automatic int unsigned operator_rank(input logic [7:0] c);
    case (c)
      CH_POW:         return 3;
      CH_MUL, CH_DIV: return 2;
      CH_ADD, CH_SUB: return 1;
      default:        return 0;
    endcase
  endfunction

  // takes one accepted request; on the end request converts the collected
  // expression and queues the prefix characters the block must produce
  task automatic predict_prefix(input logic [7:0] c, input logic eoe);
    logic [7:0] op_stack[$];
    logic [7:0] rev_out[$];
    logic [7:0] ch;
    if (infix_len < MAX_CHARS) begin
      infix_mem[infix_len] = c;
      infix_len++;
    end else begin
      // buffer full: the character is lost, the end character included
      infix_lost = 1'b1;
    end
    if (!eoe) return;
    // scan newest to oldest; parentheses swap roles in this direction
    for (int i = int'(infix_len) - 1; i >= 0; i--) begin
      ch = infix_mem[i];
      if (ch == CH_SPACE || ch == CH_TAB) begin
        continue;
      end else if (operator_rank(ch) != 0) begin
        // pop only strictly tighter operators, so ^ groups left to right
        while (op_stack.size() > 0 && operator_rank(op_stack[$]) > operator_rank(ch))
          rev_out.push_back(op_stack.pop_back());
        op_stack.push_back(ch);
      end else if (ch == CH_CLOSE) begin
        op_stack.push_back(ch);
      end else if (ch == CH_OPEN) begin
        while (op_stack.size() > 0 && op_stack[$] != CH_CLOSE)
          rev_out.push_back(op_stack.pop_back());
        // matching ')' is dropped; a lone '(' has nothing to drop
        if (op_stack.size() > 0) void'(op_stack.pop_back());
      end else begin
        rev_out.push_back(ch);
      end
    end
    // leftovers, an unmatched ')' among them, go out as well
    while (op_stack.size() > 0)
      rev_out.push_back(op_stack.pop_back());
    if (rev_out.size() == 0) begin
      expected_prefix_q.push_back('{ch: 8'h00, empty: 1'b1, lost: infix_lost, last: 1'b1});
    end else begin
      for (int k = rev_out.size() - 1; k >= 0; k--)
        expected_prefix_q.push_back('{ch: rev_out[k], empty: 1'b0, lost: infix_lost,
                                       last: (k == 0)});
    end
    infix_len  = 0;
    infix_lost = 1'b0;
  endtask

  // one request: random idle cycles first, then hold start until busy is low at an edge
  task automatic send_request(input logic [7:0] c, input logic eoe);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    in_char_i     <= c;
    end_of_expr_i <= eoe;
    do @(posedge clk_i); while (busy_o);
    predict_prefix(c, eoe);
  endtask

  // whole expression, end flag on its final character
  task automatic send_expression(input char_q_t q);
    for (int i = 0; i < q.size(); i++)
      send_request(q[i], i == q.size() - 1);
  endtask

  // drop start and hold off until every owed prefix character has come back
  task automatic wait_for_drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_prefix_q.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic char_q_t text_to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // mostly letters, some digits and high bytes
  function automatic logic [7:0] random_operand();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return 8'($urandom_range(8'h80, 8'hff));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  // any of the characters the block treats specially
  function automatic logic [7:0] random_special();
    case ($urandom_range(8))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      default: return random_operator();
    endcase
  endfunction

  // well-formed infix with random nesting and blanks
  function automatic char_q_t random_infix();
    char_q_t q;
    int      depth;
    int      n_opnd;
    depth  = 0;
    n_opnd = $urandom_range(1, 8);
    for (int k = 0; k < n_opnd; k++) begin
      if (k > 0) q.push_back(random_operator());
      if ($urandom_range(5) == 0) q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      while (depth < 4 && $urandom_range(3) == 0) begin
        q.push_back(CH_OPEN);
        depth++;
      end
      q.push_back(random_operand());
      while (depth > 0 && $urandom_range(2) == 0) begin
        q.push_back(CH_CLOSE);
        depth--;
      end
    end
    while (depth > 0) begin
      q.push_back(CH_CLOSE);
      depth--;
    end
    return q;
  endfunction

  // arbitrary bytes, weighted toward the special characters
  function automatic char_q_t random_noise(input int unsigned len);
    char_q_t q;
    for (int unsigned k = 0; k < len; k++)
      q.push_back($urandom_range(1) ? 8'($urandom_range(255)) : random_special());
    return q;
  endfunction

  // every operator, grouping, a blank and chained ^
  task automatic test_precedence_and_grouping();
    send_expression(text_to_chars("(a-b)/c^d"));
    send_expression(text_to_chars("x ^y^z*w+v"));
  endtask

  // lone ')' with a zero operand, nothing but blanks and a lone '(',
  // and a single end request carrying the top byte
  task automatic test_unmatched_and_empty();
    char_q_t q;
    q.push_back(8'h00);
    q.push_back(CH_CLOSE);
    send_expression(q);
    send_expression(text_to_chars(" (\t"));
    q.delete();
    q.push_back(8'hff);
    send_expression(q);
  endtask

  // exactly full buffer, then two characters past it so the end character is lost too
  task automatic test_buffer_capacity();
    char_q_t q;
    int      len;
    for (int pass = 0; pass < 2; pass++) begin
      len = (pass == 0) ? MAX_CHARS : MAX_CHARS + 2;
      q.delete();
      for (int k = 0; k < len; k++)
        q.push_back((k % 2 == 0) ? random_operand() : random_operator());
      send_expression(q);
    end
  endtask

  // mostly well-formed expressions, some short noise, rare near-full or overlong noise
  task automatic test_random_expressions(input int unsigned item_budget);
    char_q_t     q;
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 4) q = random_noise($urandom_range(MAX_CHARS - 4, MAX_CHARS + 6));
      else if (pick < 22) q = random_noise($urandom_range(1, 12));
      else q = random_infix();
      send_expression(q);
      sent += q.size();
    end
  endtask

  // compare each prefix character against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_prefix_q.size() == 0) begin
        $display("%0t: unexpected prefix char: expected none, actual ch=%h empty=%b ovf=%b last=%b",
                 $time, out_char_o, empty_res_o, overflow_o, last_o);
        mismatch_count++;
      end else begin
        prefix_head = expected_prefix_q.pop_front();
        // character is a don't care on the empty result
        if ((!prefix_head.empty && out_char_o !== prefix_head.ch) ||
            empty_res_o !== prefix_head.empty || overflow_o !== prefix_head.lost ||
            last_o !== prefix_head.last) begin
          $display("%0t: prefix char mismatch: expected ch=%h empty=%b ovf=%b last=%b, actual ch=%h empty=%b ovf=%b last=%b",
                   $time, prefix_head.ch, prefix_head.empty, prefix_head.lost,
                   prefix_head.last, out_char_o, empty_res_o, overflow_o, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    in_char_i       = 8'h00;
    end_of_expr_i   = 1'b0;
    infix_len       = 0;
    infix_lost      = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 13;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // light sender gaps
    test_precedence_and_grouping();
    test_unmatched_and_empty();
    test_buffer_capacity();
    test_random_expressions(105);
    wait_for_drain();

    // heavy sender gaps
    sender_idle_pct = 48;
    test_random_expressions(105);
    wait_for_drain();

    // back to back requests
    sender_idle_pct = 0;
    test_random_expressions(105);
    wait_for_drain();

    // settle time for anything stray after the last result
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_datapath.sv
rtl/i2p_controller.sv
rtl/infix_to_prefix_converter.sv
test/infix_to_prefix_converter_tb.sv
